/* src/fpst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpst_pkg;

	// field widths fixed by the command and result words
	localparam int KIND_W   = 2;
	localparam int PAGE_W   = 15;
	localparam int BLOCK_W  = 9;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 32;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PROGRAM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_PAGE   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_BLOCK  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_ALREADY    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOT_SEQ    = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIVIDE,
		S_LOOKUP,
		S_EXECUTE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic divide;
		logic lookup;
		logic execute;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_full;
	} dp_sts_t;

endpackage

`default_nettype wire

/* src/fpst_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/fpst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpst_ctrl import fpst_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output ctrl_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DIVIDE;
				end
			end
			S_DIVIDE: begin
				cmd.divide = 1'b1;
				state_d    = S_LOOKUP;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_EXECUTE;
			end
			S_EXECUTE: begin
				// hold the ram data until the result register frees up
				if (!sts.out_full) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/fpst_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpst_dpath import fpst_pkg::*; #(
	parameter int BLOCK_COUNT = 256,
	parameter int BLOCK_PAGES = 64,
	parameter int TAG_BITS    = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output dp_sts_t                  sts,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [PAGE_W-1:0]   page_number,
	input  wire logic [BLOCK_W-1:0]  block_number,
	input  wire logic [TAG_W-1:0]    tag_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic                     read_programmed,
	output logic [TAG_W-1:0]         read_tag,
	output logic [CNT_W-1:0]         read_total,
	output logic [CNT_W-1:0]         program_total,
	output logic [CNT_W-1:0]         erase_total
);

	localparam int TOTAL_PAGES = BLOCK_COUNT * BLOCK_PAGES;
	localparam int BLK_AW      = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int PG_AW       = $clog2(TOTAL_PAGES);
	localparam int OFF_W       = $clog2(BLOCK_PAGES);
	// page / BLOCK_PAGES as a multiply by a rounded-up reciprocal, exact over 15 bits
	localparam int DIV_SH      = PAGE_W + OFF_W;
	localparam int DIV_MW      = DIV_SH + 1;
	localparam int PROD_W      = PAGE_W + DIV_MW;
	localparam logic [DIV_MW-1:0] DIV_MUL =
		DIV_MW'(((2 ** DIV_SH) + BLOCK_PAGES - 1) / BLOCK_PAGES);
	localparam int BP_W        = BLK_AW + 7;

	// captured command
	logic [KIND_W-1:0]  kind_q;
	logic [PAGE_W-1:0]  page_q;
	logic [BLOCK_W-1:0] blk_in_q;
	logic [TAG_W-1:0]   tag_in_q;

	// address split
	logic [PROD_W-1:0]  div_prod;
	logic [BLK_AW-1:0]  blk_q;
	logic [BP_W-1:0]    blk_base;
	logic [OFF_W-1:0]   off_q;
	logic               pg_ok;
	logic               blk_ok;

	// clearing sweep
	logic [BLK_AW-1:0]  clr_cnt_q;

	// mark ram
	logic                   mark_we;
	logic [BLK_AW-1:0]      mark_waddr;
	logic [BLOCK_PAGES-1:0] mark_wdata;
	logic [BLOCK_PAGES-1:0] mark_rdata;
	logic [BLOCK_PAGES-1:0] mark_set;
	logic                   cur_mark;
	logic                   prev_mark;

	// tag ram
	logic                tag_we;
	logic [PG_AW-1:0]    tag_addr;
	logic [63:0]         tag_wide_in;
	logic [TAG_BITS-1:0] tag_rdata;
	logic [63:0]         tag_wide_out;

	// execute results
	logic                prog_ok;
	logic                erase_ok;
	logic [STATUS_W-1:0] st_d;
	logic                rprog_d;
	logic                rd_inc;
	logic                pg_inc;
	logic                er_inc;

	logic [CNT_W-1:0] read_cnt_q;
	logic [CNT_W-1:0] prog_cnt_q;
	logic [CNT_W-1:0] erase_cnt_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                read_programmed_q;
	logic [TAG_W-1:0]    read_tag_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			page_q   <= page_number;
			blk_in_q <= block_number;
			tag_in_q <= tag_value;
		end
		if (cmd.divide) begin
			blk_q <= div_prod[DIV_SH +: BLK_AW];
		end
		if (cmd.lookup) begin
			off_q <= page_q[OFF_W-1:0] - blk_base[OFF_W-1:0];
		end
	end

	assign div_prod = PROD_W'(page_q) * PROD_W'(DIV_MUL);
	assign blk_base = BP_W'(blk_q) * BP_W'(BLOCK_PAGES);
	assign pg_ok    = {1'b0, page_q} < (PAGE_W + 1)'(TOTAL_PAGES);
	assign blk_ok   = {1'b0, blk_in_q} < (BLOCK_W + 1)'(BLOCK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = clr_cnt_q == BLK_AW'(BLOCK_COUNT - 1);
	assign sts.out_full   = out_valid_q && !out_ready;

	assign cur_mark  = mark_rdata[off_q];
	assign prev_mark = (off_q != '0) && mark_rdata[off_q - 1'b1];
	assign mark_set  = mark_rdata | (BLOCK_PAGES'(1) << off_q);

	always_comb begin
		st_d     = STS_OK;
		rprog_d  = 1'b0;
		rd_inc   = 1'b0;
		prog_ok  = 1'b0;
		erase_ok = 1'b0;
		case (kind_q)
			KIND_READ: begin
				if (!pg_ok) begin
					st_d = STS_BAD_PAGE;
				end else begin
					rd_inc  = 1'b1;
					rprog_d = cur_mark;
				end
			end
			KIND_PROGRAM: begin
				if (!pg_ok) begin
					st_d = STS_BAD_PAGE;
				end else if (cur_mark) begin
					st_d = STS_ALREADY;
				end else if ((off_q != '0) && !prev_mark) begin
					st_d = STS_NOT_SEQ;
				end else begin
					prog_ok = 1'b1;
				end
			end
			KIND_ERASE: begin
				if (!blk_ok) begin
					st_d = STS_BAD_BLOCK;
				end else begin
					erase_ok = 1'b1;
				end
			end
			default: begin
				st_d = STS_OK;
			end
		endcase
	end

	assign pg_inc = cmd.execute && prog_ok;
	assign er_inc = cmd.execute && erase_ok;

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = blk_q;
		mark_wdata = '0;
		if (cmd.clear) begin
			mark_we    = 1'b1;
			mark_waddr = clr_cnt_q;
		end else if (pg_inc) begin
			mark_we    = 1'b1;
			mark_wdata = mark_set;
		end else if (er_inc) begin
			mark_we    = 1'b1;
			mark_waddr = blk_in_q[BLK_AW-1:0];
		end
	end

	fpst_ram #(
		.WIDTH (BLOCK_PAGES),
		.DEPTH (BLOCK_COUNT)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (cmd.lookup),
		.raddr (blk_q),
		.rdata (mark_rdata)
	);

	assign tag_we      = pg_inc;
	assign tag_addr    = page_q[PG_AW-1:0];
	assign tag_wide_in = 64'(tag_in_q);

	fpst_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (TOTAL_PAGES)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_addr),
		.wdata (tag_wide_in[TAG_BITS-1:0]),
		.re    (cmd.lookup),
		.raddr (tag_addr),
		.rdata (tag_rdata)
	);

	assign tag_wide_out = 64'(tag_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_cnt_q  <= '0;
			prog_cnt_q  <= '0;
			erase_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.execute && rd_inc && (read_cnt_q != '1)) begin
				read_cnt_q <= read_cnt_q + 1'b1;
			end
			if (pg_inc && (prog_cnt_q != '1)) begin
				prog_cnt_q <= prog_cnt_q + 1'b1;
			end
			if (er_inc && (erase_cnt_q != '1)) begin
				erase_cnt_q <= erase_cnt_q + 1'b1;
			end
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q          <= st_d;
			read_programmed_q <= rprog_d;
			read_tag_q        <= rprog_d ? tag_wide_out[TAG_W-1:0] : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign read_programmed = read_programmed_q;
	assign read_tag        = read_tag_q;
	assign read_total      = read_cnt_q;
	assign program_total   = prog_cnt_q;
	assign erase_total     = erase_cnt_q;

	a_rprog_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && read_programmed_q) |-> (status_q == STS_OK))
		else $error("programmed read reported with error status");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.execute))
		else $error("result appeared without an executed command");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((read_cnt_q >= $past(read_cnt_q)) && (prog_cnt_q >= $past(prog_cnt_q))
			&& (erase_cnt_q >= $past(erase_cnt_q))))
		else $error("operation counter went backwards");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear || cmd.lookup) |-> !tag_we)
		else $error("tag write outside of execute");

endmodule

`default_nettype wire

/* src/flash_page_state_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake             word fields
// in       sink       in_valid / in_ready   kind, page_number, block_number, tag_value
// out      source     out_valid / out_ready status, read_programmed, read_tag,
//                                           read_total, program_total, erase_total
//
// each word goes through accept, block split (reciprocal multiply), offset and
// mark/tag ram lookup, then check and write back; the split and the ram read are
// registered, and the result register is loaded at the check and write back
// after reset the mark ram is swept to zero, block by block, with in_ready low
// the check and write back waits while a previous result is still held in the
// output register; in_ready is high only while the sequencer sits idle

module flash_page_state_tracker import fpst_pkg::*; #(
	parameter int BLOCK_COUNT = 256,
	parameter int BLOCK_PAGES = 64,
	parameter int TAG_BITS    = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command words
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [PAGE_W-1:0]   page_number,
	input  wire logic [BLOCK_W-1:0]  block_number,
	input  wire logic [TAG_W-1:0]    tag_value,
	// result words
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic                     read_programmed,
	output logic [TAG_W-1:0]         read_tag,
	output logic [CNT_W-1:0]         read_total,
	output logic [CNT_W-1:0]         program_total,
	output logic [CNT_W-1:0]         erase_total
);

	// sequencer commands and datapath status
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: clear sweep, accept, split, lookup, execute
	fpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: mark and tag rams, page rule checks, counters, result register
	fpst_dpath #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_PAGES (BLOCK_PAGES),
		.TAG_BITS    (TAG_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.page_number     (page_number),
		.block_number    (block_number),
		.tag_value       (tag_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.read_programmed (read_programmed),
		.read_tag        (read_tag),
		.read_total      (read_total),
		.program_total   (program_total),
		.erase_total     (erase_total)
	);

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import fpst_pkg::*;

	// geometry the block is built with here
	localparam int BLOCK_COUNT = 256;
	localparam int BLOCK_PAGES = 64;
	localparam int TAG_BITS    = 32;
	localparam int TOTAL_PAGES = BLOCK_COUNT * BLOCK_PAGES;
	localparam logic [TAG_W-1:0] TAG_MASK =
		(TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

	// kind 3 has no name in the package; the block answers ok and does nothing
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 150;    // per idling phase, four phases
	localparam int HOLD_CYCLES  = 300;    // long receiver hold-off in the first phase
	localparam int DRAIN_CYCLES = 24;     // wait after the queue drains, for a stray result word
	localparam int CYCLE_LIMIT  = 200000; // clear sweep plus slowest run, many times over
	localparam int POOL_SIZE    = 4;

	// one command word and one result word
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PAGE_W-1:0]  page;
		logic [BLOCK_W-1:0] blk;
		logic [TAG_W-1:0]   tag;
	} flash_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                programmed;
		logic [TAG_W-1:0]    tag;
		logic [CNT_W-1:0]    reads;
		logic [CNT_W-1:0]    programs;
		logic [CNT_W-1:0]    erases;
	} flash_res_t;

	// page rule tracker: mirrors marks, tags and counters, queues the result
	// each accepted command must produce, and compares returned words in order
	class page_rule_scoreboard;
		bit [BLOCK_PAGES-1:0] marks [BLOCK_COUNT];
		bit [TAG_W-1:0]       tags [TOTAL_PAGES];
		bit [CNT_W-1:0]       reads_ok;
		bit [CNT_W-1:0]       programs_ok;
		bit [CNT_W-1:0]       erases_ok;
		flash_res_t           pending [$];
		int                   errors;

		function new();
			reads_ok    = '0;
			programs_ok = '0;
			erases_ok   = '0;
			errors      = 0;
		endfunction

		function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] cnt);
			return (&cnt) ? cnt : cnt + 1'b1;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void note_command(flash_cmd_t c);
			flash_res_t r;
			int unsigned blk;
			int unsigned off;
			r = '0;
			r.status = STS_OK;
			case (c.kind)
			KIND_READ, KIND_PROGRAM: begin
				if (c.page >= TOTAL_PAGES) begin
					r.status = STS_BAD_PAGE;
				end else begin
					blk = c.page / BLOCK_PAGES;
					off = c.page % BLOCK_PAGES;
					if (c.kind == KIND_READ) begin
						reads_ok = bump(reads_ok);
						if (marks[blk][off]) begin
							r.programmed = 1'b1;
							r.tag = tags[c.page];
						end
					end else if (marks[blk][off]) begin
						r.status = STS_ALREADY;
					end else if (off > 0 && !marks[blk][off-1]) begin
						r.status = STS_NOT_SEQ;
					end else begin
						marks[blk][off] = 1'b1;
						tags[c.page] = c.tag & TAG_MASK;
						programs_ok = bump(programs_ok);
					end
				end
			end
			KIND_ERASE: begin
				if (c.blk >= BLOCK_COUNT) begin
					r.status = STS_BAD_BLOCK;
				end else begin
					marks[c.blk] = '0;
					erases_ok = bump(erases_ok);
				end
			end
			default: ;
			endcase
			r.reads    = reads_ok;
			r.programs = programs_ok;
			r.erases   = erases_ok;
			pending.insert(pending.size(), r);
		endfunction

		task check_result(flash_res_t got);
			flash_res_t want;
			if (pending.size() == 0) begin
				report("result word with no command pending");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.programmed !== want.programmed)
				report($sformatf("read_programmed got %0b want %0b",
					got.programmed, want.programmed));
			if (got.tag !== want.tag)
				report($sformatf("read_tag got %h want %h", got.tag, want.tag));
			if (got.reads !== want.reads)
				report($sformatf("read_total got %0d want %0d", got.reads, want.reads));
			if (got.programs !== want.programs)
				report($sformatf("program_total got %0d want %0d",
					got.programs, want.programs));
			if (got.erases !== want.erases)
				report($sformatf("erase_total got %0d want %0d", got.erases, want.erases));
		endtask
	endclass

	// clock and reset; every block input starts at a known value
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind         = KIND_READ;
	logic [PAGE_W-1:0]   page_number  = '0;
	logic [BLOCK_W-1:0]  block_number = '0;
	logic [TAG_W-1:0]    tag_value    = '0;

	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                read_programmed;
	logic [TAG_W-1:0]    read_tag;
	logic [CNT_W-1:0]    read_total;
	logic [CNT_W-1:0]    program_total;
	logic [CNT_W-1:0]    erase_total;

	always #4 clk = ~clk;

	flash_page_state_tracker #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_PAGES (BLOCK_PAGES),
		.TAG_BITS    (TAG_BITS)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.page_number     (page_number),
		.block_number    (block_number),
		.tag_value       (tag_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.read_programmed (read_programmed),
		.read_tag        (read_tag),
		.read_total      (read_total),
		.program_total   (program_total),
		.erase_total     (erase_total)
	);

	page_rule_scoreboard tracker;

	// idling knobs, set by the main sequence; the receiver clears hold_request and counts hold_left down
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_request  = 1'b0;
	int hold_left     = 0;

	// blocks the well-formed traffic works on, with how far each is filled
	int unsigned pool_blk  [POOL_SIZE];
	int          pool_fill [POOL_SIZE];
	int          cur_pool  = 0;

	// both handshakes are sampled at the edge, before the edge's own updates land
	always @(posedge clk) begin : watch
		flash_cmd_t c;
		flash_res_t r;
		if (arst_n && in_valid && in_ready) begin
			c.kind = kind;
			c.page = page_number;
			c.blk  = block_number;
			c.tag  = tag_value;
			tracker.note_command(c);
		end
		if (arst_n && out_valid && out_ready) begin
			r.status     = status;
			r.programmed = read_programmed;
			r.tag        = read_tag;
			r.reads      = read_total;
			r.programs   = program_total;
			r.erases     = erase_total;
			tracker.check_result(r);
		end
	end

	// receiver: random stalls, or a long hold-off counted here when asked for
	always @(posedge clk) begin : receiver
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog
	int unsigned cycles = 0;
	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic flash_cmd_t word_of(logic [KIND_W-1:0] k, int unsigned p,
		int unsigned b, logic [TAG_W-1:0] t);
		flash_cmd_t c;
		c.kind = k;
		c.page = PAGE_W'(p);
		c.blk  = BLOCK_W'(b);
		c.tag  = t;
		return c;
	endfunction

	// offer one word; called at a rising edge, returns at the edge that takes it
	// the random gap goes first so valid is never dropped and raised in one step
	task automatic send_word(flash_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= c.kind;
		page_number  <= c.page;
		block_number <= c.blk;
		tag_value    <= c.tag;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mostly in-order programs, read-backs and erases of a few blocks,
	// the rest broken programs and fully random noise
	function automatic flash_cmd_t random_command();
		flash_cmd_t  c;
		int          r;
		int          off;
		int unsigned base;
		// unused fields stay random so every bit of every field moves
		c.kind = KIND_W'($urandom_range(3));
		c.page = PAGE_W'($urandom_range(32767));
		c.blk  = BLOCK_W'($urandom_range(511));
		c.tag  = $urandom;
		// stick with one block for a while so it can fill to its last page
		if ($urandom_range(99) < 6)
			cur_pool = $urandom_range(POOL_SIZE - 1);
		base = pool_blk[cur_pool] * BLOCK_PAGES;
		r = $urandom_range(99);
		if (r < 45) begin
			if (pool_fill[cur_pool] == BLOCK_PAGES) begin
				// full block: wipe it and start over
				c.kind = KIND_ERASE;
				c.blk  = BLOCK_W'(pool_blk[cur_pool]);
				pool_fill[cur_pool] = 0;
			end else begin
				c.kind = KIND_PROGRAM;
				c.page = PAGE_W'(base + pool_fill[cur_pool]);
				pool_fill[cur_pool]++;
			end
		end else if (r < 70) begin
			// read back, mostly from the programmed part
			if (pool_fill[cur_pool] > 0 && $urandom_range(3) != 0)
				off = $urandom_range(pool_fill[cur_pool] - 1);
			else
				off = $urandom_range(BLOCK_PAGES - 1);
			c.kind = KIND_READ;
			c.page = PAGE_W'(base + off);
		end else if (r < 72) begin
			c.kind = KIND_ERASE;
			c.blk  = BLOCK_W'(pool_blk[cur_pool]);
			pool_fill[cur_pool] = 0;
		end else if (r < 80) begin
			// program anywhere in the block: mostly rewrites and skipped pages
			off = $urandom_range(BLOCK_PAGES - 1);
			c.kind = KIND_PROGRAM;
			c.page = PAGE_W'(base + off);
			if (off == pool_fill[cur_pool])
				pool_fill[cur_pool]++;
		end else if (c.kind == KIND_ERASE) begin
			// noise erase may land on a tracked block
			for (int i = 0; i < POOL_SIZE; i++)
				if (pool_blk[i] == c.blk)
					pool_fill[i] = 0;
		end
		return c;
	endfunction

	initial begin : main
		tracker = new();

		// blocks 0 and 255 take part, the middle two are random
		pool_blk[0] = 0;
		pool_blk[1] = $urandom_range(1, 126);
		pool_blk[2] = $urandom_range(127, BLOCK_COUNT - 2);
		pool_blk[3] = BLOCK_COUNT - 1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed words; the block sweeps its marks first, in_ready stays low
		send_word(word_of(KIND_READ,    0, 9'h1FF, 32'h0));          // blank first page
		send_word(word_of(KIND_PROGRAM, 0, 0, 32'hFFFF_FFFF));
		send_word(word_of(KIND_READ,    0, 0, 32'h0));
		send_word(word_of(KIND_PROGRAM, 0, 0, 32'h1111_1111));        // already programmed
		send_word(word_of(KIND_PROGRAM, 2, 0, 32'h2222_2222));        // skips page 1
		send_word(word_of(KIND_PROGRAM, 1, 0, 32'h0));                // zero tag
		send_word(word_of(KIND_READ,    1, 0, 32'hFFFF_FFFF));
		send_word(word_of(KIND_PROGRAM, (BLOCK_COUNT - 1) * BLOCK_PAGES, 0,
			32'hA5A5_5A5A));                                          // first page, last block
		send_word(word_of(KIND_PROGRAM, TOTAL_PAGES - 1, 0, 32'h3333_3333)); // last page
		send_word(word_of(KIND_READ,    TOTAL_PAGES - 1, 0, 32'h0));
		send_word(word_of(KIND_READ,    TOTAL_PAGES, 0, 32'h0));      // one past the end
		send_word(word_of(KIND_PROGRAM, 15'h7FFF, 9'h1FF, 32'h4444_4444));
		send_word(word_of(KIND_ERASE,   15'h7FFF, BLOCK_COUNT - 1, 32'h0));
		send_word(word_of(KIND_READ,    (BLOCK_COUNT - 1) * BLOCK_PAGES, 0, 32'h0));
		send_word(word_of(KIND_ERASE,   0, BLOCK_COUNT, 32'h0));      // one past last block
		send_word(word_of(KIND_ERASE,   0, 9'h1FF, 32'hFFFF_FFFF));
		send_word(word_of(KIND_UNUSED,  15'h7FFF, 9'h1FF, 32'hFFFF_FFFF));
		send_word(word_of(KIND_ERASE,   0, 0, 32'h0));
		send_word(word_of(KIND_READ,    0, 0, 32'h0));                // erased page
		send_word(word_of(KIND_PROGRAM, 0, 0, 32'h1234_5678));
		send_word(word_of(KIND_READ,    0, 0, 32'h0));
		send_word(word_of(KIND_PROGRAM, 1, 0, 32'h8765_4321));

		// where the directed part left the tracked blocks
		pool_fill[0] = 2;
		pool_fill[1] = 0;
		pool_fill[2] = 0;
		pool_fill[3] = 0;

		// idling phases: none, sender idle, receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
				// receiver holds off while words keep coming, so the block backs up
				hold_request = 1'b1;
			end
			1: begin
				send_idle_pct = 62;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 62;
			end
			default: begin
				send_idle_pct = 14;
				stall_pct = 14;
			end
			endcase
			for (int n = 0; n < RANDOM_WORDS; n++)
				send_word(random_command());
		end
		in_valid <= 1'b0;

		// drain, then give a stray extra word a chance to show up
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
src/fpst_pkg.sv
src/fpst_ram.sv
src/fpst_ctrl.sv
src/fpst_dpath.sv
src/flash_page_state_tracker.sv
sim/tb.sv
